@@ sv/assert_macros.svh @@
// Assertion macros shared by the ribbon vertex RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RBV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RBV_ASSERT(lbl, clk, rst, prop, msg)
`define RBV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ sv/rbv_pkg.sv @@
// Types, constants and helpers of the ribbon vertex expander.
package rbv_pkg;
  localparam int COORD_BITS = 32;
  localparam int MAX_POINTS = 4096;
  localparam int IDX_W = $clog2(MAX_POINTS);

  localparam logic [2:0] CFG_CAMERA_X = 3'd0;
  localparam logic [2:0] CFG_CAMERA_Y = 3'd1;
  localparam logic [2:0] CFG_CAMERA_Z = 3'd2;
  localparam logic [2:0] CFG_RIBBON_WIDTH = 3'd3;
  localparam logic [2:0] CFG_STRIP_POINTS = 3'd4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic final_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic side_u;
    logic [16:0] v_coord;
    logic last_vertex;
  } vertex_t;

  // one point to expand: position, segment direction, index, end of strip
  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] p;
    logic [2:0][COORD_BITS:0] d;
    logic [IDX_W-1:0] idx;
    logic last;
  } job_t;

  typedef struct packed {
    logic start;
    logic [60:0] num;
    logic [30:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [30:0] quo;
  } div_resp_t;

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    logic [32:0] r;
    r = v[32] ? 33'(-v) : 33'(v);
    return r;
  endfunction

  function automatic logic [62:0] mag63(logic signed [62:0] v);
    logic [62:0] r;
    r = v[62] ? 63'(-v) : 63'(v);
    return r;
  endfunction

  // right shift that brings a 33-bit magnitude below 2^30
  function automatic logic [1:0] pre_shift(logic [32:0] o);
    logic [1:0] s;
    if (o[32]) s = 2'd3;
    else if (o[31]) s = 2'd2;
    else if (o[30]) s = 2'd1;
    else s = 2'd0;
    return s;
  endfunction
endpackage

@@ sv/rbv_fifo.sv @@
// Two-entry job queue between front and back.
`include "assert_macros.svh"
module rbv_fifo (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rbv_pkg::job_t push_data,
  output logic full,
  input  logic pop,
  output rbv_pkg::job_t head,
  output logic empty
);
  rbv_pkg::job_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `RBV_ASSERT(a_no_overflow, clk, rst, !(push && full && !pop), "job pushed into full queue")
  `RBV_ASSERT(a_no_underflow, clk, rst, !(pop && empty), "job popped from empty queue")
endmodule

@@ sv/rbv_front.sv @@
// Front end: holds the previous point and turns points into expansion jobs.
`include "assert_macros.svh"
module rbv_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rbv_pkg::point_t in_data,
  output logic push,
  output rbv_pkg::job_t push_data,
  input  logic full
);
  logic [2:0][rbv_pkg::COORD_BITS-1:0] held;
  logic have;
  logic [rbv_pkg::IDX_W-1:0] index;
  logic pend;
  rbv_pkg::job_t pend_job;
  rbv_pkg::job_t cur_job;
  logic [2:0][rbv_pkg::COORD_BITS-1:0] p;
  logic [rbv_pkg::IDX_W-1:0] next_idx;
  logic acc;

  assign in_ready = !pend && !full;
  assign acc = in_valid && in_ready;
  assign p[0] = in_data.point_x;
  assign p[1] = in_data.point_y;
  assign p[2] = in_data.point_z;
  assign next_idx = (index < rbv_pkg::IDX_W'(rbv_pkg::MAX_POINTS - 1)) ?
                    index + 1'b1 : rbv_pkg::IDX_W'(rbv_pkg::MAX_POINTS - 1);

  always_comb begin
    cur_job.p = held;
    for (int k = 0; k < 3; k++) begin
      cur_job.d[k] = {p[k][rbv_pkg::COORD_BITS-1], p[k]} -
                     {held[k][rbv_pkg::COORD_BITS-1], held[k]};
    end
    cur_job.idx = index;
    cur_job.last = 1'b0;
  end

  assign push = pend ? !full : (acc && have);
  assign push_data = pend ? pend_job : cur_job;

  always_ff @(posedge clk) begin
    if (acc && have && in_data.final_point) begin
      pend_job.p <= p;
      pend_job.d <= cur_job.d;
      pend_job.idx <= next_idx;
      pend_job.last <= 1'b1;
    end
    if (acc && !in_data.final_point) held <= p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      index <= '0;
      pend <= 1'b0;
    end else begin
      if (pend && !full) pend <= 1'b0;
      if (acc) begin
        if (!have) begin
          index <= '0;
          have <= !in_data.final_point;
        end else if (in_data.final_point) begin
          pend <= 1'b1;
          have <= 1'b0;
          index <= '0;
        end else begin
          index <= next_idx;
        end
      end
    end
  end

  `RBV_ASSERT(a_pend_blocks, clk, rst, pend |-> !in_ready, "point taken with second job pending")
endmodule

@@ sv/rbv_div.sv @@
// Restoring divider, one quotient bit per cycle, 31-bit quotient.
`include "assert_macros.svh"
module rbv_div (
  input  logic clk,
  input  logic rst,
  input  rbv_pkg::div_req_t req,
  output rbv_pkg::div_resp_t resp
);
  logic busy;
  logic [4:0] cnt;
  logic [60:0] rem, dsh;
  logic [30:0] q;
  logic done;

  assign resp.done = done;
  assign resp.quo = q;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      dsh <= {req.den, 30'b0};
      q <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q <= {q[29:0], 1'b1};
      end else begin
        q <= {q[29:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == 5'd30;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd30) busy <= 1'b0;
      end
    end
  end

  `RBV_ASSERT(a_done_after_busy, clk, rst, done |-> !busy && $past(busy), "stray divide done")
endmodule

@@ sv/rbv_back.sv @@
// Back end: offset computation sequencer and vertex output register.
module rbv_back (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  rbv_pkg::job_t head,
  output logic pop,
  input  logic [2:0][31:0] camera,
  input  logic [30:0] ribbon_width,
  input  logic [12:0] strip_points,
  output rbv_pkg::div_req_t div_req,
  input  rbv_pkg::div_resp_t div_resp,
  output logic out_valid,
  input  logic out_ready,
  output rbv_pkg::vertex_t out_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_PRESC, S_CROSS, S_NORM, S_SQUARE, S_ROOT, S_OMUL,
    S_ODIV_START, S_ODIV_WAIT, S_VDIV_START, S_VDIV_WAIT, S_EMIT
  } state_t;

  state_t st;
  rbv_pkg::job_t job;
  logic signed [30:0] ds [3];
  logic signed [30:0] es [3];
  logic signed [62:0] c [3];
  logic signed [30:0] off [3];
  logic signed [63:0] prod;
  logic signed [31:0] mul_a, mul_b;
  logic [2:0] cnt;
  logic [1:0] k;
  logic [61:0] sum, x;
  logic [62:0] r, rbit;
  logic [16:0] vq;
  logic [62:0] magc [3];
  logic [61:0] mag_or;
  logic [5:0] nsh;
  logic [29:0] half;
  logic [12:0] vdiv;
  logic [30:0] len;
  logic signed [32:0] dv [3];
  logic signed [32:0] ev [3];
  logic [1:0] sd, se;
  logic [16:0] vnew;

  assign half = ribbon_width[30:1];
  assign len = r[30:0];
  assign vdiv = (strip_points > 13'd1) ? strip_points - 13'd1 : 13'd1;
  assign pop = (st == S_IDLE) && !empty;
  assign vnew = (div_resp.quo > 31'd65536) ? 17'd65536 : div_resp.quo[16:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      magc[i] = rbv_pkg::mag63(c[i]);
      dv[i] = $signed(job.d[i]);
      ev[i] = $signed({camera[i][31], camera[i]}) - $signed({job.p[i][31], job.p[i]});
    end
    mag_or = magc[0][61:0] | magc[1][61:0] | magc[2][61:0];
    sd = rbv_pkg::pre_shift(rbv_pkg::mag33(dv[0]) | rbv_pkg::mag33(dv[1]) |
                            rbv_pkg::mag33(dv[2]));
    se = rbv_pkg::pre_shift(rbv_pkg::mag33(ev[0]) | rbv_pkg::mag33(ev[1]) |
                            rbv_pkg::mag33(ev[2]));
  end

  // cross product shift: top set bit of the largest magnitude brought down to bit 29
  always_comb begin
    nsh = '0;
    for (int b = 30; b < 62; b++) begin
      if (mag_or[b]) nsh = 6'(b - 29);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      S_CROSS: begin
        case (cnt)
          3'd0: begin mul_a = {ds[1][30], ds[1]}; mul_b = {es[2][30], es[2]}; end
          3'd1: begin mul_a = {ds[2][30], ds[2]}; mul_b = {es[1][30], es[1]}; end
          3'd2: begin mul_a = {ds[2][30], ds[2]}; mul_b = {es[0][30], es[0]}; end
          3'd3: begin mul_a = {ds[0][30], ds[0]}; mul_b = {es[2][30], es[2]}; end
          3'd4: begin mul_a = {ds[0][30], ds[0]}; mul_b = {es[1][30], es[1]}; end
          3'd5: begin mul_a = {ds[1][30], ds[1]}; mul_b = {es[0][30], es[0]}; end
          default: ;
        endcase
      end
      S_SQUARE: begin
        if (cnt < 3'd3) begin
          mul_a = {1'b0, magc[cnt[1:0]][30:0]};
          mul_b = {1'b0, magc[cnt[1:0]][30:0]};
        end
      end
      S_OMUL: begin
        mul_a = {1'b0, magc[k][30:0]};
        mul_b = {2'b0, half};
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start = (st == S_ODIV_START) || (st == S_VDIV_START);
    if (st == S_VDIV_START) begin
      div_req.num = 61'({job.idx, 16'b0}) + 61'(vdiv >> 1);
      div_req.den = 31'(vdiv);
    end else begin
      div_req.num = prod[60:0] + 61'(len >> 1);
      div_req.den = len;
    end
  end

  function automatic logic signed [31:0] vert(logic [31:0] p, logic signed [30:0] o,
                                               logic side);
    logic signed [33:0] s;
    s = side ? $signed({{2{p[31]}}, p}) + 34'(o) : $signed({{2{p[31]}}, p}) - 34'(o);
    if (s > 34'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (s < -34'sh80000000) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic rbv_pkg::vertex_t build(rbv_pkg::job_t j, logic signed [30:0] o0,
                                             logic signed [30:0] o1, logic signed [30:0] o2,
                                             logic side, logic [16:0] v);
    rbv_pkg::vertex_t t;
    t.vertex_x = vert(j.p[0], o0, side);
    t.vertex_y = vert(j.p[1], o1, side);
    t.vertex_z = vert(j.p[2], o2, side);
    t.side_u = side;
    t.v_coord = v;
    t.last_vertex = j.last && side;
    return t;
  endfunction

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      st <= S_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
      k <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (!empty) begin
            job <= head;
            st <= S_PRESC;
          end
        end
        S_PRESC: begin
          for (int i = 0; i < 3; i++) begin
            ds[i] <= 31'(dv[i] >>> sd);
            es[i] <= 31'(ev[i] >>> se);
          end
          cnt <= '0;
          st <= S_CROSS;
        end
        S_CROSS: begin
          // product of step cnt-1 lands now; even steps load, odd steps subtract
          case (cnt)
            3'd1: c[0] <= prod[62:0];
            3'd2: c[0] <= c[0] - prod[62:0];
            3'd3: c[1] <= prod[62:0];
            3'd4: c[1] <= c[1] - prod[62:0];
            3'd5: c[2] <= prod[62:0];
            3'd6: c[2] <= c[2] - prod[62:0];
            default: ;
          endcase
          cnt <= cnt + 1'b1;
          if (cnt == 3'd6) st <= S_NORM;
        end
        S_NORM: begin
          for (int i = 0; i < 3; i++) c[i] <= c[i] >>> nsh;
          cnt <= '0;
          sum <= '0;
          st <= S_SQUARE;
        end
        S_SQUARE: begin
          if (cnt != 3'd0) sum <= sum + prod[61:0];
          cnt <= cnt + 1'b1;
          if (cnt == 3'd3) begin
            x <= sum + prod[61:0];
            r <= '0;
            rbit <= 63'(1) << 62;
            st <= S_ROOT;
          end
        end
        S_ROOT: begin
          if ({1'b0, x} >= r + rbit) begin
            x <= 62'({1'b0, x} - (r + rbit));
            r <= (r >> 1) + rbit;
          end else begin
            r <= r >> 1;
          end
          rbit <= rbit >> 2;
          if (rbit == 63'd1) begin
            k <= '0;
            st <= S_OMUL;
          end
        end
        S_OMUL: begin
          if (len == '0) begin
            off[k] <= '0;
            k <= k + 1'b1;
            if (k == 2'd2) st <= S_VDIV_START;
          end else begin
            st <= S_ODIV_START;
          end
        end
        S_ODIV_START: st <= S_ODIV_WAIT;
        S_ODIV_WAIT: begin
          if (div_resp.done) begin
            off[k] <= c[k][62] ? 31'(-$signed({1'b0, div_resp.quo})) :
                                 $signed(div_resp.quo);
            k <= k + 1'b1;
            st <= (k == 2'd2) ? S_VDIV_START : S_OMUL;
          end
        end
        S_VDIV_START: st <= S_VDIV_WAIT;
        S_VDIV_WAIT: begin
          if (div_resp.done) begin
            vq <= vnew;
            out_data <= build(job, off[0], off[1], off[2], 1'b0, vnew);
            out_valid <= 1'b1;
            st <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (!out_data.side_u) begin
              out_data <= build(job, off[0], off[1], off[2], 1'b1, vq);
            end else begin
              out_valid <= 1'b0;
              st <= S_IDLE;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/ribbon_billboard_vertices.sv @@
// Top level of the camera-facing ribbon vertex expander.
//
//   channel | direction | handshake            | payload
//   in      | in        | in_valid / in_ready  | in_data  (point_t)
//   out     | out       | out_valid/ out_ready | out_data (vertex_t)
//   cfg     | in        | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// Each job (one per point of a strip) goes through the back end in order:
// 6 cross products and 3 squares through one shared 32x32 multiplier,
// one normalize shift, a 32-step square root, three offset divides
// (multiply, start, 31 steps, done) and a v divide; then two output vertices.
// A zero cross product skips the offset divides.
// A point arriving with no point held yields no item.
// Reset (rst, synchronous) clears control state; registers take their reset values.
// The two-entry job queue lets the front keep taking points while the back works
// or while out_ready holds a finished vertex item.
`include "assert_macros.svh"
module ribbon_billboard_vertices (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rbv_pkg::point_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rbv_pkg::vertex_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  logic [2:0][31:0] camera;
  logic [30:0] ribbon_width;
  logic [12:0] strip_points;

  logic push, full, pop, empty;
  rbv_pkg::job_t push_data, head;
  rbv_pkg::div_req_t div_req;
  rbv_pkg::div_resp_t div_resp;
  logic last_out;

  // cfg always taken; sender must write only while the block is idle (unchecked)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera <= '0;
      ribbon_width <= 31'd65536;
      strip_points <= 13'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        rbv_pkg::CFG_CAMERA_X: camera[0] <= cfg_data;
        rbv_pkg::CFG_CAMERA_Y: camera[1] <= cfg_data;
        rbv_pkg::CFG_CAMERA_Z: camera[2] <= cfg_data;
        rbv_pkg::CFG_RIBBON_WIDTH: ribbon_width <= cfg_data[30:0];
        rbv_pkg::CFG_STRIP_POINTS: strip_points <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  rbv_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .push(push), .push_data(push_data), .full(full)
  );

  rbv_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .push_data(push_data), .full(full),
    .pop(pop), .head(head), .empty(empty)
  );

  rbv_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .resp(div_resp)
  );

  rbv_back u_back (
    .clk(clk), .rst(rst),
    .empty(empty), .head(head), .pop(pop),
    .camera(camera), .ribbon_width(ribbon_width), .strip_points(strip_points),
    .div_req(div_req), .div_resp(div_resp),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  assign last_out = out_valid && out_data.last_vertex;

  // the end-of-strip mark only rides on a plus-side vertex
  `RBV_ASSERT(a_last_plus, clk, rst, last_out |-> out_data.side_u, "last vertex on minus side")
endmodule
